@@ hdl/lfd_pkg.sv @@
// Shared constants and types for the lidar frame deframer.
package lfd_pkg;

   // Frame header byte, sent twice at the start of every frame
   localparam logic [7:0] HDR_BYTE = 8'h59;

   // Index of the ninth (checksum) byte within a frame
   localparam logic [3:0] FRAME_LAST = 4'd8;

   // Frame byte indexes with special meaning
   localparam logic [3:0] POS_HUNT    = 4'd0;
   localparam logic [3:0] POS_HDR2    = 4'd1;
   localparam logic [3:0] POS_DIST_LO = 4'd2;
   localparam logic [3:0] POS_DIST_HI = 4'd3;
   localparam logic [3:0] POS_STR_LO  = 4'd4;
   localparam logic [3:0] POS_STR_HI  = 4'd5;
   localparam logic [3:0] POS_SPARE0  = 4'd6;
   localparam logic [3:0] POS_SPARE1  = 4'd7;

   typedef logic [3:0] frame_pos_type;

endpackage : lfd_pkg

@@ hdl/lidar_frame_deframer_top.sv @@
// Top level of the lidar frame deframer: byte stream in, measurement stream out.
//
// Usage:
//   req_* carries received sensor bytes, one per transaction, in req_tdata.
//   The block hunts for two 0x59 header bytes, collects seven more bytes and
//   on the ninth byte of a frame issues one rsp_* transaction holding the
//   distance (bytes 2-3) and strength (bytes 4-5), little endian, with
//   rsp_tuser high when the ninth byte equals the 8-bit sum of bytes 0 to 7.
//   A bad second header byte drops the frame and hunting starts over.
// Output: the result is registered and appears on rsp_* in the cycle after the ninth byte is taken.
// Throughput: one byte per cycle while no result is held back by rsp_tready;
//   the frame counter, sum and capture registers update on each accepted byte,
//   and the result register is the only storage between the two sides.
// Reset: synchronous, active high; clears the frame position and the result
//   valid, so the block starts hunting for a header with no result pending.
// Stall: while a result waits on a low rsp_tready, req_tready drops so no new
//   byte is taken; when the result is taken in the same cycle, a new byte is
//   accepted alongside it.
module lidar_frame_deframer_top (
   input  logic        clock,
   input  logic        reset,
   // byte input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   // measurement result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] distance, [31:16] strength
   output logic [0:0]  rsp_tuser    // [0] checksum_ok
);

   lfd_pkg::frame_pos_type pos_ff, pos_in;
   logic [7:0]  sum_ff, sum_in;
   logic [15:0] dist_ff, dist_in;
   logic [15:0] str_ff, str_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_dist_ff, rsp_dist_in;
   logic [15:0] rsp_str_ff, rsp_str_in;
   logic        rsp_ok_ff, rsp_ok_in;

   logic        req_fire;
   lfd_pkg::frame_pos_type pos_cur;

   // Take a byte whenever the result register is empty or being drained
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   // Out-of-range positions behave as hunting
   assign pos_cur = (pos_ff > lfd_pkg::FRAME_LAST) ? lfd_pkg::POS_HUNT : pos_ff;

   // Frame tracking and result formation
   always_comb begin
      pos_in       = pos_ff;
      sum_in       = sum_ff;
      dist_in      = dist_ff;
      str_in       = str_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_dist_in  = rsp_dist_ff;
      rsp_str_in   = rsp_str_ff;
      rsp_ok_in    = rsp_ok_ff;
      if (req_fire) begin
         pos_in = pos_cur;
         case (pos_cur)
            lfd_pkg::POS_HUNT: begin
               if (req_tdata == lfd_pkg::HDR_BYTE) begin
                  sum_in  = req_tdata;
                  dist_in = '0;
                  str_in  = '0;
                  pos_in  = lfd_pkg::POS_HDR2;
               end
            end
            lfd_pkg::POS_HDR2: begin
               if (req_tdata == lfd_pkg::HDR_BYTE) begin
                  sum_in = sum_ff + req_tdata;
                  pos_in = lfd_pkg::POS_DIST_LO;
               end else begin
                  pos_in = lfd_pkg::POS_HUNT;
               end
            end
            lfd_pkg::POS_DIST_LO: begin
               dist_in = {dist_ff[15:8], req_tdata};
               sum_in  = sum_ff + req_tdata;
               pos_in  = lfd_pkg::POS_DIST_HI;
            end
            lfd_pkg::POS_DIST_HI: begin
               dist_in = {req_tdata, dist_ff[7:0]};
               sum_in  = sum_ff + req_tdata;
               pos_in  = lfd_pkg::POS_STR_LO;
            end
            lfd_pkg::POS_STR_LO: begin
               str_in = {str_ff[15:8], req_tdata};
               sum_in = sum_ff + req_tdata;
               pos_in = lfd_pkg::POS_STR_HI;
            end
            lfd_pkg::POS_STR_HI: begin
               str_in = {req_tdata, str_ff[7:0]};
               sum_in = sum_ff + req_tdata;
               pos_in = lfd_pkg::POS_SPARE0;
            end
            lfd_pkg::POS_SPARE0, lfd_pkg::POS_SPARE1: begin
               sum_in = sum_ff + req_tdata;
               pos_in = pos_cur + 4'd1;
            end
            default: begin
               // checksum byte: issue the measurement
               rsp_valid_in = 1'b1;
               rsp_dist_in  = dist_ff;
               rsp_str_in   = str_ff;
               rsp_ok_in    = (req_tdata == sum_ff);
               pos_in       = lfd_pkg::POS_HUNT;
            end
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= lfd_pkg::POS_HUNT;
         sum_ff       <= '0;
         dist_ff      <= '0;
         str_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         sum_ff       <= sum_in;
         dist_ff      <= dist_in;
         str_ff       <= str_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload register
   always_ff @(posedge clock) begin
      rsp_dist_ff <= rsp_dist_in;
      rsp_str_ff  <= rsp_str_in;
      rsp_ok_ff   <= rsp_ok_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {rsp_str_ff, rsp_dist_ff};
   assign rsp_tuser[0] = rsp_ok_ff;

   // The checksum byte always produces a result next cycle
   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_fire && pos_cur == lfd_pkg::FRAME_LAST) |=> rsp_valid_ff)
      else $error("checksum byte did not produce a result");

   // A result appears only after a checksum byte was accepted
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_fire && pos_cur == lfd_pkg::FRAME_LAST))
      else $error("result raised without a checksum byte");

   // Frame position stays within the frame
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= lfd_pkg::FRAME_LAST)
      else $error("frame position out of range");

   // A non-header byte while hunting keeps the block hunting
   a_hunt_stays: assert property (@(posedge clock) disable iff (reset)
      (req_fire && pos_cur == lfd_pkg::POS_HUNT && req_tdata != lfd_pkg::HDR_BYTE)
      |=> pos_ff == lfd_pkg::POS_HUNT)
      else $error("left hunting on a non-header byte");

endmodule : lidar_frame_deframer_top
